FILE: hdl/vnoh_pkg.sv
// ----------------------------------------------------------------------------
// Value noise octave height: shared package
// Sizes, formats, hash constants, the cosine blend table and the item types.
// ----------------------------------------------------------------------------
package vnoh_pkg;

	localparam int MAX_OCTAVES       = 8;
	localparam int COORD_BITS        = 10;
	localparam int COS_TABLE_ENTRIES = 256;

	localparam int NS_BITS      = 16;
	localparam int DIM_BITS     = 11;
	localparam int FIX_BITS     = COORD_BITS + NS_BITS + 8;
	localparam int TX_BITS      = 48;
	localparam int OCT_IDX_BITS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int COS_IDX_BITS = $clog2(COS_TABLE_ENTRIES);
	localparam int COS_BITS     = 17;
	localparam int AMP_BITS     = 17;
	localparam int NOISE_BITS   = 32;
	localparam int PROD_BITS    = NOISE_BITS + AMP_BITS + 1;
	localparam int OCT_LVLS     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int OCT_LANES    = 1 << OCT_LVLS;
	localparam int SUM_BITS     = PROD_BITS + OCT_LVLS;
	localparam int FIFO_DEPTH   = 2;

	// Pipeline depths, counted in register stages.
	localparam int FRONT_LAT = 1 + FIX_BITS;
	localparam int OCT_LAT   = 10;
	localparam int BACK_LAT  = OCT_LAT + OCT_LVLS + 4;
	localparam int TOTAL_LAT = FRONT_LAT + 1 + BACK_LAT;

	localparam logic [31:0] HASH_MUL   = 32'd15731;
	localparam logic [31:0] HASH_ADD   = 32'd789221;
	localparam logic [31:0] HASH_OFS   = 32'd1376312589;
	localparam int          HASH_SHIFT = 13;
	localparam logic [31:0] ROW_STRIDE = 32'd57;
	localparam logic signed [31:0] NOISE_ONE = 32'sd1073741824;

	localparam logic [AMP_BITS-1:0] AMP_ONE = 17'h10000;
	localparam logic [AMP_BITS-1:0] AMP_MAX = 17'h1FFFF;
	localparam int BYTE_SHIFT = 39;
	localparam logic signed [SUM_BITS-1:0] BYTE_BIAS = SUM_BITS'(64'sd1 <<< 46);
	localparam logic [16:0] RECIP_255 = 17'h08081;
	localparam int RECIP_SHIFT = 23;

	localparam longint unsigned PI_Q28 = 64'd843314857;

	typedef enum logic [2:0] {
		REG_SEED,
		REG_NOISE_SCALE,
		REG_PERSISTENCE,
		REG_OCTAVE_COUNT,
		REG_MAP_WIDTH,
		REG_MAP_HEIGHT,
		REG_MAX_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]         seed;
		logic [NS_BITS-1:0]  noise_scale;
		logic [15:0]         persistence;
		logic [3:0]          octave_count;
		logic [DIM_BITS-1:0] map_width;
		logic [DIM_BITS-1:0] map_height;
		logic [15:0]         max_height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
	} in_t;

	typedef struct packed {
		logic [7:0]  height_byte;
		logic [15:0] height_value;
	} out_t;

	typedef struct packed {
		logic [FIX_BITS-1:0] xf;
		logic [FIX_BITS-1:0] yf;
	} coord_t;

	typedef logic [COS_TABLE_ENTRIES-1:0][COS_BITS-1:0] cos_tab_t;

	// Shift-and-subtract quotient, used only while the table is built.
	function automatic longint unsigned div_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k holds (1 - cos(pi*k/N))/2 in Q0.16 from a Taylor series in Q4.28.
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		longint r;
		tab = '0;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			x = (PI_Q28 * longint'(k)) >> COS_IDX_BITS;
			term = 64'd1 << 28;
			sum = longint'(term);
			for (int j = 1; j <= 8; j++) begin
				term = ((term * x) >> 28) * x >> 28;
				term = div_u64(term, 64'((2 * j - 1) * (2 * j)));
				if ((j & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			r = (64'sd1 <<< 28) - sum + (64'sd1 <<< 12);
			r = r >>> 13;
			if (r < 0) begin
				r = 0;
			end
			if (r > 65536) begin
				r = 65536;
			end
			tab[k] = COS_BITS'(r);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

FILE: hdl/vnoh_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a new dividend may enter every cycle.
// ----------------------------------------------------------------------------
module vnoh_div (
	input  logic                           clk,
	input  logic [vnoh_pkg::FIX_BITS-1:0]  dividend,
	input  logic [vnoh_pkg::DIM_BITS-1:0]  divisor,
	output logic [vnoh_pkg::FIX_BITS-1:0]  quotient
);
	import vnoh_pkg::*;

	logic [DIM_BITS-1:0] rem_q [FIX_BITS];
	logic [FIX_BITS-1:0] num_q [FIX_BITS];

	for (genvar k = 0; k < FIX_BITS; k++) begin : g_stage
		logic [DIM_BITS-1:0] rem_in;
		logic [FIX_BITS-1:0] num_in;
		logic [DIM_BITS:0]   cand;
		logic [DIM_BITS:0]   diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign num_in = num_q[k-1];
		end

		always_comb begin
			cand = {rem_in, num_in[FIX_BITS-1]};
			diff = cand - {1'b0, divisor};
			ge   = cand >= {1'b0, divisor};
		end

		// The dividend shifts out at the top while quotient bits enter below.
		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? diff[DIM_BITS-1:0] : cand[DIM_BITS-1:0];
			num_q[k] <= {num_in[FIX_BITS-2:0], ge};
		end
	end

	assign quotient = num_q[FIX_BITS-1];

endmodule

FILE: hdl/vnoh_front.sv
// ----------------------------------------------------------------------------
// Front end: point to lattice coordinates
// Scales column and row and divides by the map size in Q18.16.
// ----------------------------------------------------------------------------
module vnoh_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  vnoh_pkg::in_t    item,
	input  vnoh_pkg::cfg_t   cfg,
	output logic             push,
	output vnoh_pkg::coord_t coord
);
	import vnoh_pkg::*;

	logic [FIX_BITS-1:0]  dx_s1;
	logic [FIX_BITS-1:0]  dy_s1;
	logic [DIM_BITS-1:0]  wdiv;
	logic [DIM_BITS-1:0]  hdiv;
	logic [FRONT_LAT-1:0] vld_q;

	// A map size of zero divides as one.
	assign wdiv = (cfg.map_width == '0) ? DIM_BITS'(1) : cfg.map_width;
	assign hdiv = (cfg.map_height == '0) ? DIM_BITS'(1) : cfg.map_height;

	always_ff @(posedge clk) begin
		dx_s1 <= {(COORD_BITS + NS_BITS)'(item.column * cfg.noise_scale), 8'h00};
		dy_s1 <= {(COORD_BITS + NS_BITS)'(item.row * cfg.noise_scale), 8'h00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_LAT-2:0], accept};
		end
	end

	vnoh_div u_div_x (
		.clk      (clk),
		.dividend (dx_s1),
		.divisor  (wdiv),
		.quotient (coord.xf)
	);

	vnoh_div u_div_y (
		.clk      (clk),
		.dividend (dy_s1),
		.divisor  (hdiv),
		.quotient (coord.yf)
	);

	assign push = vld_q[FRONT_LAT-1];

endmodule

FILE: hdl/vnoh_fifo.sv
// ----------------------------------------------------------------------------
// Coordinate queue
// Short queue between the front end and the octave pipelines.
// ----------------------------------------------------------------------------
module vnoh_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vnoh_pkg::coord_t wdata,
	input  logic             pop,
	output logic             out_valid,
	output vnoh_pkg::coord_t rdata,
	output logic             full
);
	import vnoh_pkg::*;

	localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

	coord_t              mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_pop;

	assign out_valid = count_q != '0;
	assign full      = count_q == CNT_BITS'(FIFO_DEPTH);
	assign do_pop    = pop && out_valid;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> do_pop)
		else $error("coordinate queue written while full");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(FIFO_DEPTH))
		else $error("coordinate queue count out of range");

endmodule

FILE: hdl/vnoh_octave.sv
// ----------------------------------------------------------------------------
// One octave lane
// Hashes four lattice corners, blends them with the cosine table and
// weights the result by the octave amplitude.
// ----------------------------------------------------------------------------
module vnoh_octave (
	input  logic                                   clk,
	input  logic [vnoh_pkg::FIX_BITS-1:0]          xf,
	input  logic [vnoh_pkg::FIX_BITS-1:0]          yf,
	input  logic [vnoh_pkg::OCT_IDX_BITS-1:0]      octave,
	input  logic [31:0]                            seed,
	input  logic [vnoh_pkg::AMP_BITS-1:0]          amp,
	output logic signed [vnoh_pkg::PROD_BITS-1:0]  contrib
);
	import vnoh_pkg::*;

	localparam logic [31:0] CORNER_OFS [4] = '{32'd0, 32'd1, ROW_STRIDE, ROW_STRIDE + 32'd1};

	logic [TX_BITS-1:0] tx;
	logic [TX_BITS-1:0] ty;

	logic [31:0]             base_s1;
	logic [COS_IDX_BITS-1:0] fx_s1, fx_s2, fx_s3, fx_s4, fx_s5;
	logic [COS_IDX_BITS-1:0] fy_s1, fy_s2, fy_s3, fy_s4, fy_s5, fy_s6, fy_s7;
	logic [31:0]             n_s2  [4];
	logic [31:0]             nx_s3 [4];
	logic [31:0]             sq_s3 [4];
	logic [31:0]             nx_s4 [4];
	logic [31:0]             m_s4  [4];
	logic signed [31:0]      v_s5  [4];
	logic signed [32:0]      d1_s6, d2_s6;
	logic signed [31:0]      a1_s6, a2_s6;
	logic [COS_BITS-1:0]     px_s6;
	logic signed [31:0]      i1_s7, i2_s7;
	logic signed [32:0]      dy_s8;
	logic signed [31:0]      ay_s8;
	logic [COS_BITS-1:0]     py_s8;
	logic signed [31:0]      blend_s9;

	logic signed [COS_BITS+33:0] prod1;
	logic signed [COS_BITS+33:0] prod2;
	logic signed [COS_BITS+33:0] prody;

	always_comb begin
		tx = TX_BITS'(xf) << octave;
		ty = TX_BITS'(yf) << octave;
		prod1 = d1_s6 * $signed({1'b0, px_s6});
		prod2 = d2_s6 * $signed({1'b0, px_s6});
		prody = dy_s8 * $signed({1'b0, py_s8});
	end

	always_ff @(posedge clk) begin
		// Lattice base index; all integer parts wrap mod 2^32.
		base_s1 <= tx[47:16] + ty[47:16] * ROW_STRIDE + seed;
		fx_s1   <= tx[15 -: COS_IDX_BITS];
		fy_s1   <= ty[15 -: COS_IDX_BITS];

		fx_s2 <= fx_s1;
		fx_s3 <= fx_s2;
		fx_s4 <= fx_s3;
		fx_s5 <= fx_s4;
		fy_s2 <= fy_s1;
		fy_s3 <= fy_s2;
		fy_s4 <= fy_s3;
		fy_s5 <= fy_s4;
		fy_s6 <= fy_s5;
		fy_s7 <= fy_s6;

		for (int c = 0; c < 4; c++) begin
			n_s2[c]  <= base_s1 + CORNER_OFS[c];
			nx_s3[c] <= (n_s2[c] << HASH_SHIFT) ^ n_s2[c];
			sq_s3[c] <= 32'(((n_s2[c] << HASH_SHIFT) ^ n_s2[c]) *
				((n_s2[c] << HASH_SHIFT) ^ n_s2[c]));
			nx_s4[c] <= nx_s3[c];
			m_s4[c]  <= 32'(sq_s3[c] * HASH_MUL) + HASH_ADD;
			v_s5[c]  <= NOISE_ONE - $signed({1'b0, 31'(32'(nx_s4[c] * m_s4[c]) + HASH_OFS)});
		end

		// Blend along x for both rows, then along y.
		d1_s6 <= 33'(v_s5[1]) - 33'(v_s5[0]);
		d2_s6 <= 33'(v_s5[3]) - 33'(v_s5[2]);
		a1_s6 <= v_s5[0];
		a2_s6 <= v_s5[2];
		px_s6 <= COS_TAB[fx_s5];

		i1_s7 <= a1_s6 + 32'(prod1 >>> 16);
		i2_s7 <= a2_s6 + 32'(prod2 >>> 16);

		dy_s8 <= 33'(i2_s7) - 33'(i1_s7);
		ay_s8 <= i1_s7;
		py_s8 <= COS_TAB[fy_s7];

		blend_s9 <= ay_s8 + 32'(prody >>> 16);

		contrib <= blend_s9 * $signed({1'b0, amp});
	end

endmodule

FILE: hdl/vnoh_back.sv
// ----------------------------------------------------------------------------
// Back end: octave lanes, weighted sum and height scaling
// Takes one coordinate pair per cycle from the queue and registers the result.
// ----------------------------------------------------------------------------
module vnoh_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  vnoh_pkg::coord_t coord,
	input  vnoh_pkg::cfg_t   cfg,
	output logic             pop,
	output logic             done,
	output vnoh_pkg::out_t   result
);
	import vnoh_pkg::*;

	logic [AMP_BITS-1:0]          w_q      [MAX_OCTAVES];
	logic [AMP_BITS-1:0]          lane_amp [MAX_OCTAVES];
	logic signed [PROD_BITS-1:0]  contrib  [MAX_OCTAVES];
	logic signed [SUM_BITS-1:0]   leaf     [OCT_LANES];
	logic signed [SUM_BITS-1:0]   tree_q   [1:OCT_LVLS][OCT_LANES];
	logic [BACK_LAT-1:0]          vld_q;

	logic signed [SUM_BITS-1:0] biased;
	logic signed [SUM_BITS-1:0] shifted;
	logic [7:0]                 byte_s1;
	logic [7:0]                 byte_s2;
	logic [23:0]                scaled_s2;
	logic [7:0]                 byte_s3;
	logic [23:0]                scaled_s3;
	logic [16:0]                quot_s3;
	logic [40:0]                recip;

	function automatic logic [AMP_BITS-1:0] next_amp(input logic [AMP_BITS-1:0] a,
		input logic [15:0] p);
		logic [AMP_BITS+15:0] prod;
		logic [AMP_BITS+15:0] sh;
		prod = a * p;
		sh   = prod >> 15;
		return (sh > (AMP_BITS+16)'(AMP_MAX)) ? AMP_MAX : sh[AMP_BITS-1:0];
	endfunction

	assign pop = in_valid;

	// Weights are registered octave by octave after a persistence write and settle
	// long before any item accepted after the write reaches the weighting stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_OCTAVES; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			w_q[0] <= AMP_ONE;
			for (int i = 1; i < MAX_OCTAVES; i++) begin
				w_q[i] <= next_amp(w_q[i-1], cfg.persistence);
			end
		end
	end

	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
		assign lane_amp[g] = (32'(cfg.octave_count) > g) ? w_q[g] : '0;

		vnoh_octave u_octave (
			.clk     (clk),
			.xf      (coord.xf),
			.yf      (coord.yf),
			.octave  (OCT_IDX_BITS'(g)),
			.seed    (cfg.seed),
			.amp     (lane_amp[g]),
			.contrib (contrib[g])
		);
	end

	for (genvar j = 0; j < OCT_LANES; j++) begin : g_leaf
		if (j < MAX_OCTAVES) begin : g_used
			assign leaf[j] = SUM_BITS'(contrib[j]);
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	for (genvar l = 1; l <= OCT_LVLS; l++) begin : g_lvl
		for (genvar j = 0; j < (OCT_LANES >> l); j++) begin : g_node
			if (l == 1) begin : g_first
				always_ff @(posedge clk) begin
					tree_q[l][j] <= leaf[2*j] + leaf[2*j+1];
				end
			end else begin : g_upper
				always_ff @(posedge clk) begin
					tree_q[l][j] <= tree_q[l-1][2*j] + tree_q[l-1][2*j+1];
				end
			end
		end
	end

	always_comb begin
		biased  = tree_q[OCT_LVLS][0] + BYTE_BIAS;
		shifted = biased >>> BYTE_SHIFT;
		recip   = scaled_s2 * RECIP_255;
	end

	// Division by 255 uses a reciprocal that may overshoot by one; the last
	// stage corrects it.
	always_ff @(posedge clk) begin
		if (shifted < 0) begin
			byte_s1 <= 8'h00;
		end else if (shifted > SUM_BITS'(255)) begin
			byte_s1 <= 8'hFF;
		end else begin
			byte_s1 <= shifted[7:0];
		end
		byte_s2   <= byte_s1;
		scaled_s2 <= byte_s1 * cfg.max_height;
		byte_s3   <= byte_s2;
		scaled_s3 <= scaled_s2;
		quot_s3   <= recip[RECIP_SHIFT +: 17];
		result.height_byte <= byte_s3;
		if (({quot_s3, 8'h00} - 25'(quot_s3)) > 25'(scaled_s3)) begin
			result.height_value <= 16'(quot_s3 - 17'd1);
		end else begin
			result.height_value <= quot_s3[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BACK_LAT-2:0], in_valid};
		end
	end

	assign done = vld_q[BACK_LAT-1];

	a_value_bound : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.height_value <= cfg.max_height)
		else $error("height value above the configured maximum");

	a_full_byte : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.height_byte == 8'hFF |-> result.height_value == cfg.max_height)
		else $error("full-scale byte does not map to the maximum height");

endmodule

FILE: hdl/value_noise_octave_height.sv
// ----------------------------------------------------------------------------
// Value noise octave height generator
// Fractal value-noise terrain height for one grid point per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a grid point on item; it is taken at any clock edge
//   where busy is low. busy reflects the coordinate queue being full and
//   stays low in normal operation, so one point can enter every cycle.
//   Each result appears on result for one cycle with done high, in order.
//   The receiver cannot stall the block; results are not held.
//   Between a point and its result lie the front end's one-bit-per-stage
//   dividers (34 stages), the ten-stage octave lanes, the octave adder
//   tree and the output scaling stages.
//   The user must write the registers over the APB port only while no
//   point is in flight; the block itself does not enforce this.
//   After a persistence write the octave weights settle one octave after
//   another. Reset clears all control state and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module value_noise_octave_height (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vnoh_pkg::in_t  item,
	output logic           done,
	output vnoh_pkg::out_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import vnoh_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     accept;
	logic     push;
	coord_t   push_coord;
	logic     q_valid;
	coord_t   q_coord;
	logic     pop;
	logic     q_full;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign accept  = start && !busy;
	assign busy    = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed         <= 32'd0;
			cfg_q.noise_scale  <= 16'd256;
			cfg_q.persistence  <= 16'd16384;
			cfg_q.octave_count <= 4'd1;
			cfg_q.map_width    <= 11'd1024;
			cfg_q.map_height   <= 11'd1024;
			cfg_q.max_height   <= 16'd5120;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SEED:         cfg_q.seed         <= pwdata;
				REG_NOISE_SCALE:  cfg_q.noise_scale  <= pwdata[15:0];
				REG_PERSISTENCE:  cfg_q.persistence  <= pwdata[15:0];
				REG_OCTAVE_COUNT: cfg_q.octave_count <= pwdata[3:0];
				REG_MAP_WIDTH:    cfg_q.map_width    <= pwdata[DIM_BITS-1:0];
				REG_MAP_HEIGHT:   cfg_q.map_height   <= pwdata[DIM_BITS-1:0];
				REG_MAX_HEIGHT:   cfg_q.max_height   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SEED:         prdata = cfg_q.seed;
			REG_NOISE_SCALE:  prdata = 32'(cfg_q.noise_scale);
			REG_PERSISTENCE:  prdata = 32'(cfg_q.persistence);
			REG_OCTAVE_COUNT: prdata = 32'(cfg_q.octave_count);
			REG_MAP_WIDTH:    prdata = 32'(cfg_q.map_width);
			REG_MAP_HEIGHT:   prdata = 32'(cfg_q.map_height);
			REG_MAX_HEIGHT:   prdata = 32'(cfg_q.max_height);
			default:          prdata = 32'd0;
		endcase
	end

	vnoh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.push   (push),
		.coord  (push_coord)
	);

	vnoh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_coord),
		.pop       (pop),
		.out_valid (q_valid),
		.rdata     (q_coord),
		.full      (q_full)
	);

	vnoh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.coord    (q_coord),
		.cfg      (cfg_q),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, TOTAL_LAT))
		else $error("result beat without a matching accepted point");

	a_queue_drains : assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> pop)
		else $error("octave lanes refused a queued point");

	a_never_busy : assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("coordinate queue filled up");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Value noise octave height testbench
// Drives grid points with random gaps, programs the registers over APB between
// phases and checks every result against a behavioral model or a fixed byte.
// ----------------------------------------------------------------------------
module testbench;
	import vnoh_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         item;
	logic        done;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	value_noise_octave_height dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the register file.
	logic [31:0] sh_seed;
	logic [15:0] sh_scale;
	logic [15:0] sh_persist;
	logic [3:0]  sh_octaves;
	logic [10:0] sh_width;
	logic [10:0] sh_height;
	logic [15:0] sh_maxh;

	int unsigned blend_tab [COS_TABLE_ENTRIES];
	out_t        heights_due [$];
	int          errors = 0;
	int          cycles = 0;
	bit          quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Results cannot be held off, so every strobe is one beat.
	always @(posedge clk) begin
		out_t want;
		if (done) begin
			if (heights_due.size() == 0) begin
				$display("%0t: unexpected result byte=%0d value=%0d", $time,
					result.height_byte, result.height_value);
				errors++;
			end else begin
				want = heights_due.pop_front();
				if (result.height_byte !== want.height_byte) begin
					$display("%0t: height_byte expected %0d actual %0d", $time,
						want.height_byte, result.height_byte);
					errors++;
				end
				if (result.height_value !== want.height_value) begin
					$display("%0t: height_value expected %0d actual %0d", $time,
						want.height_value, result.height_value);
					errors++;
				end
			end
		end
	end

	function automatic void fill_blend_tab();
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		longint          r;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			x = 64'd843314857 * k / COS_TABLE_ENTRIES;
			term = 64'd1 << 28;
			acc = longint'(term);
			for (int j = 1; j <= 8; j++) begin
				term = ((term * x) >> 28) * x >> 28;
				term = term / ((2 * j - 1) * (2 * j));
				acc = (j % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			r = ((64'sd1 <<< 28) - acc + (64'sd1 <<< 12)) >>> 13;
			if (r < 0) r = 0;
			if (r > 65536) r = 65536;
			blend_tab[k] = 32'(r);
		end
	endfunction

	function automatic longint corner_value(logic [31:0] n);
		logic [31:0] m;
		logic [31:0] t;
		m = (n << 13) ^ n;
		t = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
		return 64'sd1073741824 - longint'({32'd0, t});
	endfunction

	function automatic longint mix(longint a, longint b, logic [15:0] frac);
		int unsigned idx;
		idx = (frac * COS_TABLE_ENTRIES) >> 16;
		return a + (((b - a) * longint'(blend_tab[idx])) >>> 16);
	endfunction

	function automatic out_t terrain_height(in_t pt);
		longint unsigned w, h, xf, yf, tx, ty, amp;
		longint      total, b, i1, i2;
		logic [31:0] base;
		int          oct;
		out_t        o;
		w = (sh_width == 0) ? 1 : sh_width;
		h = (sh_height == 0) ? 1 : sh_height;
		xf = ((longint'(pt.column) * sh_scale) << 8) / w;
		yf = ((longint'(pt.row) * sh_scale) << 8) / h;
		oct = (sh_octaves > MAX_OCTAVES) ? MAX_OCTAVES : sh_octaves;
		amp = 65536;
		total = 0;
		for (int i = 0; i < oct; i++) begin
			tx = xf << i;
			ty = yf << i;
			base = tx[47:16] + ty[47:16] * 32'd57 + sh_seed;
			i1 = mix(corner_value(base), corner_value(base + 32'd1), tx[15:0]);
			i2 = mix(corner_value(base + 32'd57), corner_value(base + 32'd58), tx[15:0]);
			total += mix(i1, i2, ty[15:0]) * longint'(amp);
			amp = (amp * sh_persist) >> 15;
			if (amp > 64'h1ffff) amp = 64'h1ffff;
		end
		b = (total + (64'sd1 <<< 46)) >>> 39;
		if (b < 0) b = 0;
		if (b > 255) b = 255;
		o.height_byte = b[7:0];
		o.height_value = 16'((b * sh_maxh) / 255);
		return o;
	endfunction

	// Leaves the bus selected; the caller closes the transfer.
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SEED:         sh_seed = val;
			REG_NOISE_SCALE:  sh_scale = val[15:0];
			REG_PERSISTENCE:  sh_persist = val[15:0];
			REG_OCTAVE_COUNT: sh_octaves = val[3:0];
			REG_MAP_WIDTH:    sh_width = val[10:0];
			REG_MAP_HEIGHT:   sh_height = val[10:0];
			REG_MAX_HEIGHT:   sh_maxh = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [31:0] sd, logic [15:0] sc, logic [15:0] ps,
			logic [3:0] oc, logic [10:0] w, logic [10:0] h, logic [15:0] mh);
		// Results must all be back before the registers move.
		while (heights_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_write(REG_SEED, sd);
		reg_write(REG_NOISE_SCALE, {16'd0, sc});
		reg_write(REG_PERSISTENCE, {16'd0, ps});
		reg_write(REG_OCTAVE_COUNT, {28'd0, oc});
		reg_write(REG_MAP_WIDTH, {21'd0, w});
		reg_write(REG_MAP_HEIGHT, {21'd0, h});
		reg_write(REG_MAX_HEIGHT, {16'd0, mh});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Let the octave weights settle after a persistence write.
		repeat (10) @(posedge clk);
	endtask

	// A byte of -1 means the predictor supplies the expectation.
	task automatic send_point(logic [9:0] col, logic [9:0] rw, int fixed_byte);
		in_t  pt;
		out_t want;
		bit   taken;
		pt.column = col;
		pt.row = rw;
		if (!quiet && $urandom_range(0, 99) < 5) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= pt;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		if (fixed_byte >= 0) begin
			want.height_byte = fixed_byte[7:0];
			want.height_value = 16'((fixed_byte * sh_maxh) / 255);
		end else begin
			want = terrain_height(pt);
		end
		heights_due = {heights_due, want};
	endtask

	task automatic idle_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	typedef struct {
		logic [9:0] col;
		logic [9:0] rw;
		int         byte_due;
	} point_row_t;

	point_row_t reset_rows [7] = '{
		'{10'd0, 10'd0, 91},
		'{10'd1023, 10'd1023, -1},
		'{10'd1023, 10'd0, -1},
		'{10'd0, 10'd1023, -1},
		'{10'd512, 10'd512, -1},
		'{10'd341, 10'd682, -1},
		'{10'd1, 10'd1, -1}
	};

	initial begin
		logic [9:0] c, r;
		int         lim_w, lim_h;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		sh_seed = 32'd0;
		sh_scale = 16'd256;
		sh_persist = 16'd16384;
		sh_octaves = 4'd1;
		sh_width = 11'd1024;
		sh_height = 11'd1024;
		sh_maxh = 16'd5120;
		fill_blend_tab();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset defaults first.
		foreach (reset_rows[k])
			send_point(reset_rows[k].col, reset_rows[k].rw, reset_rows[k].byte_due);
		idle_start();

		// With no octaves the total is zero and the byte sits at mid scale.
		set_all(32'h8000_0000, 16'hffff, 16'hffff, 4'd0, 11'd1024, 11'd1024, 16'hffff);
		send_point(10'd1023, 10'd1023, 128);
		send_point(10'd0, 10'd0, 128);
		idle_start();

		// Octave count beyond the maximum, full persistence, large lattice.
		set_all(32'h7fff_ffff, 16'hffff, 16'hffff, 4'd15, 11'd1024, 11'd1024, 16'd0);
		send_point(10'd1023, 10'd1023, -1);
		send_point(10'd777, 10'd3, -1);
		idle_start();

		// Zero map size and points outside a tiny map.
		set_all(32'hdead_beef, 16'd0, 16'd0, 4'd8, 11'd0, 11'd0, 16'd5120);
		send_point(10'd5, 10'd9, -1);
		idle_start();
		set_all(32'h1234_5678, 16'h0180, 16'd40000, 4'd8, 11'd1, 11'd2047, 16'hffff);
		send_point(10'd1023, 10'd1023, -1);
		send_point(10'd600, 10'd0, -1);
		send_point(10'd0, 10'd1023, -1);
		idle_start();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_all(32'd0, 16'd256, 16'd16384, 4'd1, 11'd1024, 11'd1024, 16'd5120);
				1: set_all($urandom, 16'($urandom), 16'($urandom), 4'd8, 11'd1024,
					11'd1024, 16'($urandom));
				2: set_all(32'h8000_0000, 16'hffff, 16'd32768, 4'd4, 11'd640,
					11'd480, 16'hffff);
				3: set_all($urandom, 16'($urandom_range(1, 2048)), 16'hffff, 4'd8,
					11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), 16'($urandom));
				9: set_all($urandom, 16'($urandom), 16'($urandom), 4'($urandom),
					11'($urandom), 11'($urandom), 16'($urandom));
				default: set_all($urandom, 16'($urandom), 16'($urandom),
					4'($urandom_range(1, 8)), 11'($urandom_range(1, 1024)),
					11'($urandom_range(1, 1024)), 16'($urandom));
			endcase
			lim_w = (sh_width == 0 || sh_width > 1024) ? 1024 : sh_width;
			lim_h = (sh_height == 0 || sh_height > 1024) ? 1024 : sh_height;
			for (int n = 0; n < 55; n++) begin
				quiet = (ph == 4);
				if ($urandom_range(0, 9) == 0) begin
					c = 10'($urandom);
					r = 10'($urandom);
				end else begin
					c = 10'($urandom_range(0, lim_w - 1));
					r = 10'($urandom_range(0, lim_h - 1));
				end
				send_point(c, r, -1);
			end
			quiet = 1'b0;
			idle_start();
		end

		while (heights_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
